>>> rtl/smtp_body_line_normalize_dot_stuff_core_macros.svh
// Assertion macros for the SMTP body normalizer core.
// Used by the top level; needs aclk and aresetn in scope.
`ifndef SMTP_BODY_LINE_NORMALIZE_DOT_STUFF_CORE_MACROS_SVH
`define SMTP_BODY_LINE_NORMALIZE_DOT_STUFF_CORE_MACROS_SVH

// check a property on every clock edge outside reset
`define SMTPDOT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that a condition is followed by another in the next cycle
`define SMTPDOT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (prop)) else $error(msg);

`endif

>>> rtl/smtpdot_pkg.sv
// Shared types, constants and byte tables for the SMTP body normalizer.
// No dependencies.
package smtpdot_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_DOT = 8'h2E;

    localparam int unsigned TERM_LEN = 5;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PLAIN,
        KIND_STUFF,
        KIND_CRLF
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       eob;
        logic       term;
    } desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic       busy;
        logic [2:0] idx;
        logic [2:0] count;
    } back_status_t;

    function automatic logic [7:0] term_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CH_CR;
            3'd1:    b = CH_LF;
            3'd2:    b = CH_DOT;
            3'd3:    b = CH_CR;
            3'd4:    b = CH_LF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] body_len(input kind_t kind);
        logic [1:0] n;
        unique case (kind)
            KIND_NONE:  n = 2'd0;
            KIND_PLAIN: n = 2'd1;
            KIND_STUFF: n = 2'd2;
            KIND_CRLF:  n = 2'd2;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/smtpdot_front.sv
// Front end: accepts body bytes, tracks line state, classifies each item.
// Depends on smtpdot_pkg.
module smtpdot_front import smtpdot_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic          cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tuser,
    input  logic          s_tlast,
    input  queue_status_t q_status,
    output logic          push,
    output desc_t         push_desc
);

    logic  term_en_reg, term_en_next;
    logic  after_cr_reg, after_cr_next;
    logic  line_start_reg, line_start_next;
    logic  accept;
    kind_t kind;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        priority if (!s_tuser) begin
            kind = KIND_NONE;
        end else if (after_cr_reg && s_tdata == CH_LF) begin
            kind = KIND_NONE;
        end else if (s_tdata == CH_CR || s_tdata == CH_LF) begin
            kind = KIND_CRLF;
        end else if (line_start_reg && s_tdata == CH_DOT) begin
            kind = KIND_STUFF;
        end else begin
            kind = KIND_PLAIN;
        end
    end

    always_comb begin
        term_en_next    = cfg_valid ? cfg_data : term_en_reg;
        after_cr_next   = after_cr_reg;
        line_start_next = line_start_reg;
        if (accept) begin
            if (s_tuser) begin
                after_cr_next = (s_tdata == CH_CR);
                if (kind == KIND_CRLF) begin
                    line_start_next = 1'b1;
                end else if (kind != KIND_NONE) begin
                    line_start_next = 1'b0;
                end
            end
            if (s_tlast) begin
                after_cr_next   = 1'b0;
                line_start_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_en_reg    <= 1'b1;
            after_cr_reg   <= 1'b0;
            line_start_reg <= 1'b1;
        end else begin
            term_en_reg    <= term_en_next;
            after_cr_reg   <= after_cr_next;
            line_start_reg <= line_start_next;
        end
    end

    assign push_desc.kind = kind;
    assign push_desc.data = s_tdata;
    assign push_desc.eob  = s_tlast;
    assign push_desc.term = s_tlast && term_en_reg;

    assign push = accept && (kind != KIND_NONE || (s_tlast && term_en_reg));

endmodule

>>> rtl/smtpdot_queue.sv
// Short descriptor queue between front and back end.
// Depends on smtpdot_pkg.
module smtpdot_queue import smtpdot_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  desc_t         push_desc,
    input  logic          pop,
    output desc_t         pop_desc,
    output queue_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    desc_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign pop_desc     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

>>> rtl/smtpdot_back.sv
// Back end: expands each descriptor into output bytes, one per cycle while m_tready allows,
// into a registered stream output. Depends on smtpdot_pkg.
module smtpdot_back import smtpdot_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_status_t q_status,
    input  desc_t         q_desc,
    output logic          pop,
    output back_status_t  status,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast
);

    desc_t      cur_reg, cur_next;
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;

    logic [1:0] blen;
    logic [2:0] count;
    logic [7:0] cur_byte;
    logic       out_adv, emit, done;

    assign blen    = body_len(cur_reg.kind);
    assign count   = {1'b0, blen} + (cur_reg.term ? 3'(TERM_LEN) : 3'd0);
    assign out_adv = !m_tvalid_reg || m_tready;
    assign emit    = busy_reg && out_adv;
    assign done    = emit && (idx_reg == count - 3'd1);
    assign pop     = !q_status.empty && (!busy_reg || done);

    always_comb begin
        if (idx_reg < {1'b0, blen}) begin
            unique case (cur_reg.kind)
                KIND_CRLF:  cur_byte = (idx_reg == 3'd0) ? CH_CR : CH_LF;
                KIND_STUFF: cur_byte = (idx_reg == 3'd0) ? CH_DOT : cur_reg.data;
                KIND_PLAIN: cur_byte = cur_reg.data;
                KIND_NONE:  cur_byte = cur_reg.data;
            endcase
        end else begin
            cur_byte = term_byte(idx_reg - {1'b0, blen});
        end
    end

    always_comb begin
        cur_next      = pop ? q_desc : cur_reg;
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (out_adv) begin
            m_tvalid_next = emit;
            m_tdata_next  = cur_byte;
            m_tlast_next  = done && cur_reg.eob;
        end
        if (emit) begin
            idx_next = idx_reg + 3'd1;
        end
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg      <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cur_reg      <= cur_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign status.busy  = busy_reg;
    assign status.idx   = idx_reg;
    assign status.count = count;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> rtl/smtp_body_line_normalize_dot_stuff_core.sv
// Top level of the SMTP body normalizer with dot stuffing.
// Depends on smtpdot_pkg, smtpdot_front, smtpdot_queue, smtpdot_back and the macros header.
//
//   channel   dir  data                      flags
//   s_*       in   tdata[7:0] in_byte        tuser has_byte, tlast end_of_body
//   m_*       out  tdata[7:0] out_byte       tlast last_out
//   cfg_*     in   cfg_data terminator_enable
//
// The back end sends one byte per cycle while m_tready allows; an item
// expands to 0 to 7 output bytes (none for a dropped LF or an empty flush,
// 1 for a plain byte, 2 for a line end or stuffed dot, plus 5 with the terminator).
// The front end takes one item per cycle while the queue has room.
// Reset is synchronous; no clearing pass.
// A stalled m_tready holds the output register and fills the queue,
// which then drops s_tready.
`include "smtp_body_line_normalize_dot_stuff_core_macros.svh"
module smtp_body_line_normalize_dot_stuff_core import smtpdot_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,     // terminator_enable
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] in_byte
    input  logic       s_tuser,      // [0] has_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_byte
    output logic       m_tlast
);

    queue_status_t q_status;
    back_status_t  b_status;
    desc_t         push_desc, pop_desc;
    logic          push, pop;

    assign cfg_ready = 1'b1;

    smtpdot_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_status  (q_status),
        .push      (push),
        .push_desc (push_desc)
    );

    smtpdot_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .status    (q_status)
    );

    smtpdot_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_desc   (pop_desc),
        .pop      (pop),
        .status   (b_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `SMTPDOT_ASSERT(a_push_not_full, !(push && q_status.full), "push into full queue")
    `SMTPDOT_ASSERT(a_pop_not_empty, !(pop && q_status.empty), "pop from empty queue")
    `SMTPDOT_ASSERT(a_idx_in_range, !b_status.busy || (b_status.idx < b_status.count),
        "back end index past descriptor length")
    `SMTPDOT_ASSERT_NEXT(a_pop_busy, pop, b_status.busy && b_status.idx == 3'd0,
        "popped descriptor not started")

endmodule
